// ----- src/lbn_pkg.sv -----
package lbn_pkg;

   // neuron size and derived widths
   localparam int N_INPUTS = 16;
   localparam int ADDR_W   = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
   localparam int CNT_W    = $clog2(N_INPUTS + 1);

   // field and arithmetic widths
   localparam int TYPE_W  = 3;
   localparam int IDX_W   = 8;
   localparam int MU_W    = 16;
   localparam int W_W     = 32;
   localparam int SUM_W   = 40;
   localparam int XV_W    = 2;
   localparam int ERR_W   = SUM_W + 1;
   localparam int LO_W    = 24;
   localparam int HI_W    = ERR_W - LO_W;
   localparam int PLO_W   = LO_W + MU_W;
   localparam int PHI_W   = HI_W + MU_W + 1;
   localparam int PROD_W  = PHI_W + LO_W;
   localparam int RND_SHIFT = 15;
   localparam int DELTA_W = PROD_W - RND_SHIFT;
   localparam int UPD_W   = DELTA_W + 1;

   localparam logic [MU_W-1:0] STEP_SIZE_RESET = 16'd655;

   // training targets, Q16.16
   localparam logic signed [ERR_W-1:0] TARGET_POS = 41'sd65536;
   localparam logic signed [ERR_W-1:0] TARGET_NEG = -41'sd65536;

   // round half up before the shift
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (RND_SHIFT - 1);

   // saturation bounds, extended to the update width
   localparam logic signed [UPD_W-1:0] W_MAX_EXT = {{(UPD_W-W_W+1){1'b0}}, {(W_W-1){1'b1}}};
   localparam logic signed [UPD_W-1:0] W_MIN_EXT = {{(UPD_W-W_W+1){1'b1}}, {(W_W-1){1'b0}}};

   typedef enum logic [TYPE_W-1:0] {
      OP_SET_POS       = 3'd0,
      OP_SET_NEG       = 3'd1,
      OP_INVERT        = 3'd2,
      OP_RESET_INPUTS  = 3'd3,
      OP_CLEAR_WEIGHTS = 3'd4,
      OP_TRAIN_POS     = 3'd5,
      OP_TRAIN_NEG     = 3'd6,
      OP_QUERY         = 3'd7
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic              accept;
      logic              apply;
      logic              acc_clr;
      logic              acc_add_bias;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              upd;
      logic              err_load;
      logic              mul_lo;
      logic              mul_hi;
      logic              delta_load;
      logic              bias_upd;
      logic              out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic train;
   } status_type;

   function automatic logic signed [W_W-1:0] sat32(input logic signed [UPD_W-1:0] v);
      logic signed [W_W-1:0] r;
      if (v > W_MAX_EXT) begin
         r = W_MAX_EXT[W_W-1:0];
      end else if (v < W_MIN_EXT) begin
         r = W_MIN_EXT[W_W-1:0];
      end else begin
         r = v[W_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- src/lbn_ctrl.sv -----
module lbn_ctrl
   import lbn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type st,
   output cmd_type    cmd
);

   typedef enum logic [11:0] {
      S_IDLE     = 12'b000000000001,
      S_APPLY    = 12'b000000000010,
      S_SUM      = 12'b000000000100,
      S_SUM_BIAS = 12'b000000001000,
      S_ERR      = 12'b000000010000,
      S_MUL_LO   = 12'b000000100000,
      S_MUL_HI   = 12'b000001000000,
      S_DELTA    = 12'b000010000000,
      S_UPD      = 12'b000100000000,
      S_UPD_BIAS = 12'b001000000000,
      S_FIN_BIAS = 12'b010000000000,
      S_DONE     = 12'b100000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             pass_end;

   assign pass_end  = (cnt_ff == CNT_W'(N_INPUTS));
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // sequencing
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.apply   = 1'b1;
            cmd.acc_clr = 1'b1;
            cnt_in      = '0;
            state_in    = S_SUM;
         end
         S_SUM: begin
            if (!pass_end) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = cnt_ff[ADDR_W-1:0];
               cnt_in      = cnt_ff + 1'b1;
            end else begin
               state_in = S_SUM_BIAS;
            end
         end
         S_SUM_BIAS: begin
            cmd.acc_add_bias = 1'b1;
            state_in = st.train ? S_ERR : S_DONE;
         end
         S_ERR: begin
            cmd.err_load = 1'b1;
            state_in     = S_MUL_LO;
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_DELTA;
         end
         S_DELTA: begin
            cmd.delta_load = 1'b1;
            cmd.acc_clr    = 1'b1;
            cnt_in         = '0;
            state_in       = S_UPD;
         end
         S_UPD: begin
            cmd.upd = 1'b1;
            if (!pass_end) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = cnt_ff[ADDR_W-1:0];
               cnt_in      = cnt_ff + 1'b1;
            end else begin
               state_in = S_UPD_BIAS;
            end
         end
         S_UPD_BIAS: begin
            cmd.bias_upd = 1'b1;
            state_in     = S_FIN_BIAS;
         end
         S_FIN_BIAS: begin
            cmd.acc_add_bias = 1'b1;
            state_in         = S_DONE;
         end
         S_DONE: begin
            // wait for the output slot to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output slot occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/lbn_datapath.sv -----
module lbn_datapath
   import lbn_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [TYPE_W-1:0]       req_type,
   input  logic [IDX_W-1:0]        req_input_index,
   input  logic                    csr_valid,
   input  logic [MU_W-1:0]         csr_step_size,
   input  cmd_type                 cmd,
   output status_type              st,
   output logic signed [SUM_W-1:0] rsp_sum_out,
   output logic signed [XV_W-1:0]  rsp_input_value,
   output logic signed [W_W-1:0]   rsp_weight_value,
   output logic signed [W_W-1:0]   rsp_bias_value
);

   // latched transaction
   op_type                  op_ff;
   logic [IDX_W-1:0]        idx_ff;

   // neuron state
   logic [N_INPUTS-1:0]     bits_ff;
   logic [N_INPUTS-1:0]     wvalid_ff;
   logic signed [W_W-1:0]   weight_mem [N_INPUTS];
   logic signed [W_W-1:0]   bias_ff, bias_in;
   logic [MU_W-1:0]         step_ff;

   // weight read pipeline
   logic                    rd_vld_ff;
   logic [ADDR_W-1:0]       rd_addr_ff;
   logic signed [W_W-1:0]   rd_data_ff;
   logic                    rd_ok_ff;

   // arithmetic
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic signed [W_W-1:0]    cap_w_ff;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic [PLO_W-1:0]         plo_ff;
   logic signed [PHI_W-1:0]  phi_ff, phi_in;
   logic signed [DELTA_W-1:0] delta_ff;

   logic                     idx_ok;
   logic [ADDR_W-1:0]        idx_a;
   logic signed [W_W-1:0]    w_rd;
   logic                     x_rd;
   logic signed [UPD_W-1:0]  w_sum;
   logic signed [W_W-1:0]    w_new;
   logic signed [W_W-1:0]    w_term;
   logic signed [HI_W-1:0]   err_hi;
   logic signed [MU_W:0]     mu_s;
   logic signed [PROD_W-1:0] prod_hi, prod_lo, prod_sum, prod_shr;

   assign idx_ok   = (idx_ff < IDX_W'(N_INPUTS));
   assign idx_a    = idx_ff[ADDR_W-1:0];
   assign st.train = (op_ff == OP_TRAIN_POS) || (op_ff == OP_TRAIN_NEG);

   // weight seen on the read pipe; entries not written since reset or the last clear read as zero
   assign w_rd  = rd_ok_ff ? rd_data_ff : '0;
   assign x_rd  = bits_ff[rd_addr_ff];
   assign w_sum = x_rd ? (UPD_W'(w_rd) + UPD_W'(delta_ff))
                       : (UPD_W'(w_rd) - UPD_W'(delta_ff));
   assign w_new  = sat32(w_sum);
   assign w_term = cmd.upd ? w_new : w_rd;

   // split product: err * mu = (hi * mu) << LO_W + lo * mu
   assign err_hi   = err_ff[ERR_W-1:LO_W];
   assign mu_s     = {1'b0, step_ff};
   assign phi_in   = err_hi * mu_s;
   assign prod_hi  = PROD_W'(phi_ff) <<< LO_W;
   assign prod_lo  = signed'(PROD_W'(plo_ff));
   assign prod_sum = prod_hi + prod_lo + ROUND_HALF;
   assign prod_shr = prod_sum >>> RND_SHIFT;

   always_comb begin
      if (op_ff == OP_TRAIN_POS) begin
         err_in = TARGET_POS - ERR_W'(acc_ff);
      end else begin
         err_in = TARGET_NEG - ERR_W'(acc_ff);
      end
   end

   // accumulator
   always_comb begin
      acc_in = acc_ff;
      priority if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (cmd.acc_add_bias) begin
         acc_in = acc_ff + SUM_W'(bias_ff);
      end else if (rd_vld_ff) begin
         acc_in = x_rd ? (acc_ff + SUM_W'(w_term)) : (acc_ff - SUM_W'(w_term));
      end
   end

   // bias next value
   always_comb begin
      bias_in = bias_ff;
      priority if (cmd.apply && (op_ff == OP_CLEAR_WEIGHTS)) begin
         bias_in = '0;
      end else if (cmd.bias_upd) begin
         bias_in = sat32(UPD_W'(bias_ff) + UPD_W'(delta_ff));
      end
   end

   // control state: inputs, valid bits, bias, step size, read pipe valid
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff   <= '0;
         wvalid_ff <= '0;
         bias_ff   <= '0;
         step_ff   <= STEP_SIZE_RESET;
         rd_vld_ff <= 1'b0;
      end else begin
         bias_ff   <= bias_in;
         rd_vld_ff <= cmd.rd_en;
         if (csr_valid) begin
            step_ff <= csr_step_size;
         end
         if (cmd.apply) begin
            unique case (op_ff)
               OP_SET_POS:       if (idx_ok) bits_ff[idx_a] <= 1'b1;
               OP_SET_NEG:       if (idx_ok) bits_ff[idx_a] <= 1'b0;
               OP_INVERT:        if (idx_ok) bits_ff[idx_a] <= ~bits_ff[idx_a];
               OP_RESET_INPUTS:  bits_ff <= '0;
               OP_CLEAR_WEIGHTS: wvalid_ff <= '0;
               default: ;
            endcase
         end
         if (rd_vld_ff && cmd.upd) begin
            wvalid_ff[rd_addr_ff] <= 1'b1;
         end
      end
   end

   // weight memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (rd_vld_ff && cmd.upd) begin
         weight_mem[rd_addr_ff] <= w_new;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= weight_mem[cmd.rd_addr];
         rd_ok_ff   <= wvalid_ff[cmd.rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= op_type'(req_type);
         idx_ff <= req_input_index;
      end
      if (cmd.rd_en) begin
         rd_addr_ff <= cmd.rd_addr;
      end
      acc_ff <= acc_in;
      // keep the addressed weight as it streams past
      if (rd_vld_ff && (rd_addr_ff == idx_a)) begin
         cap_w_ff <= w_term;
      end
      if (cmd.err_load) begin
         err_ff <= err_in;
      end
      if (cmd.mul_lo) begin
         plo_ff <= err_ff[LO_W-1:0] * step_ff;
      end
      if (cmd.mul_hi) begin
         phi_ff <= phi_in;
      end
      if (cmd.delta_load) begin
         delta_ff <= prod_shr[DELTA_W-1:0];
      end
      if (cmd.out_load) begin
         rsp_sum_out    <= acc_ff;
         rsp_bias_value <= bias_ff;
         if (idx_ok) begin
            rsp_input_value  <= bits_ff[idx_a] ? 2'sb01 : 2'sb11;
            rsp_weight_value <= cap_w_ff;
         end else begin
            rsp_input_value  <= '0;
            rsp_weight_value <= '0;
         end
      end
   end

endmodule

// ----- src/lms_bipolar_neuron_trainer_unit.sv -----
// LMS neuron with N_INPUTS (16) bipolar inputs, Q16.16 weights and bias that saturate,
// and a Q0.16 learning rate written through the csr port (reset 655). Each request
// transaction edits the inputs, clears the weights and the bias, trains toward +1 or
// -1, or just queries, and returns one response: the output after the operation, the
// addressed input and weight (zero when the index is out of range) and the bias. Items
// are processed one at a time; the weights sit in a memory with a single read port, so
// every pass reads them one by one. A non-training item makes one pass and adds the
// bias; a training item makes one pass for the old output, forms the error, the low
// and high halves of the split multiply and the rounded step, then makes one
// read-modify-write pass that also forms the new output, and last updates and adds the
// bias.
// A finished response waits in its own register, so the next request is taken as
// soon as the result is handed over to that register.
module lms_bipolar_neuron_trainer_unit
   import lbn_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [TYPE_W-1:0]       req_type,
   input  logic [IDX_W-1:0]        req_input_index,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [SUM_W-1:0] rsp_sum_out,
   output logic signed [XV_W-1:0]  rsp_input_value,
   output logic signed [W_W-1:0]   rsp_weight_value,
   output logic signed [W_W-1:0]   rsp_bias_value,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [MU_W-1:0]         csr_step_size
);

   cmd_type    cmd;
   status_type st;

   // always ready; the step size is meant to change only between transactions
   assign csr_ready = 1'b1;

   lbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .cmd       (cmd)
   );

   lbn_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_type         (req_type),
      .req_input_index  (req_input_index),
      .csr_valid        (csr_valid),
      .csr_step_size    (csr_step_size),
      .cmd              (cmd),
      .st               (st),
      .rsp_sum_out      (rsp_sum_out),
      .rsp_input_value  (rsp_input_value),
      .rsp_weight_value (rsp_weight_value),
      .rsp_bias_value   (rsp_bias_value)
   );

   // busy right after taking a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while the previous one is in progress");

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("response register overwritten");

   // weight reads stay within the neuron
   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (CNT_W'(cmd.rd_addr) < CNT_W'(N_INPUTS)))
      else $error("weight read beyond the last input");

   // the reported input is -1, +1 or zero
   a_input_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_input_value != 2'sb10))
      else $error("invalid input value code");

endmodule
